>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the block clock, switched off while in reset
`define FEP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression that must never be true at a clock edge
`define FEP_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

>>> rtl/fep_pkg.sv
`default_nettype none

package fep_pkg;

  localparam int HeatW     = 3;
  localparam int ColourW   = 24;
  localparam int NumPalette = 5;
  localparam int CfgIdxW   = $clog2(NumPalette);

  localparam logic [HeatW-1:0] HeatMax = 3'd4;

  typedef logic [ColourW-1:0] rgb_t;

  localparam rgb_t PaletteReset [NumPalette] = '{
    24'h000000, 24'hFF0000, 24'hFFA500, 24'hFFFF00, 24'hFFFFFF
  };

  typedef enum logic [1:0] {
    CMD_INIT      = 2'd0,
    CMD_PROPAGATE = 2'd1,
    CMD_READ      = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROP,
    ST_READ
  } state_e;

  // result handed from the sequencer to the colour stage
  typedef struct packed {
    logic             valid;
    logic             blank;
    logic [HeatW-1:0] heat;
    logic             done;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/fep_grid_ram.sv
`default_nettype none

module fep_grid_ram import fep_pkg::*; #(
  parameter int Depth = 19200,
  parameter int AddrW = 15
) (
  input  wire logic             clk_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [HeatW-1:0] rdata_o,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [HeatW-1:0] wdata_i
);

  logic [HeatW-1:0] mem [Depth];
  logic [HeatW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/fep_palette.sv
`default_nettype none

module fep_palette import fep_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ColourW-1:0] cfg_data_i,
  input  wire res_t               res_i,
  output rgb_t                    colour_o
);

  rgb_t palette_q [NumPalette];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= PaletteReset;
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumPalette))) begin
      palette_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // an unused command gives a blank result: heat and colour are all zero
  always_comb begin
    if (res_i.blank) begin
      colour_o = '0;
    end else if (res_i.heat <= HeatMax) begin
      colour_o = palette_q[res_i.heat];
    end else begin
      colour_o = palette_q[0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/fep_seq.sv
`default_nettype none

module fep_seq import fep_pkg::*; #(
  parameter int GridWidth  = 160,
  parameter int GridHeight = 120,
  parameter int AddrW      = 15
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [1:0]       rand_bits_i,
  input  wire logic [7:0]       col_i,
  input  wire logic [6:0]       row_i,
  output logic                  ram_re_o,
  output logic      [AddrW-1:0] ram_raddr_o,
  input  wire logic [HeatW-1:0] ram_rdata_i,
  output logic                  ram_we_o,
  output logic      [AddrW-1:0] ram_waddr_o,
  output logic      [HeatW-1:0] ram_wdata_o,
  output res_t                  res_o
);

  localparam int Cells      = GridWidth * GridHeight;
  localparam int ColW       = $clog2(GridWidth);
  localparam int RowW       = $clog2(GridHeight);
  localparam int XW         = ColW + 1;
  localparam int BottomBase = (GridHeight - 1) * GridWidth;

  state_e state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             emit_init_q, emit_init_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] base_q, base_d;   // first cell of the row above
  logic [AddrW-1:0] addr_q, addr_d;   // cell being handled
  logic [1:0]       rand_q, rand_d;
  res_t             res_q, res_d;

  logic             clr_last;
  logic             in_range;
  logic [AddrW-1:0] read_addr;
  logic [XW-1:0]    xp1;
  logic [XW-1:0]    rx;
  logic [XW-1:0]    drift;
  logic [ColW-1:0]  nx;
  logic [HeatW-1:0] w;

  assign busy     = (state_q != ST_IDLE);
  assign clr_last = (clr_q == AddrW'(Cells - 1));
  assign in_range = (32'(col_i) < 32'(GridWidth)) && (32'(row_i) < 32'(GridHeight));
  assign read_addr = AddrW'(32'(row_i) * 32'(GridWidth) + 32'(col_i));

  // target column x+1-r, clamped to the grid
  assign xp1   = XW'(col_q) + XW'(1);
  assign rx    = XW'(rand_q);
  assign drift = xp1 - rx;

  always_comb begin
    if (ram_rdata_i == '0) begin
      nx = col_q;
      w  = '0;
    end else begin
      if (xp1 < rx) begin
        nx = '0;
      end else if (drift > XW'(GridWidth - 1)) begin
        nx = ColW'(GridWidth - 1);
      end else begin
        nx = drift[ColW-1:0];
      end
      w = ram_rdata_i - {{(HeatW-1){1'b0}}, rand_q[0]};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (cmd_i)
            CMD_INIT:      state_d = ST_CLEAR;
            CMD_PROPAGATE: state_d = ST_PROP;
            CMD_READ:      if (in_range) state_d = ST_READ;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_PROP: state_d = ST_IDLE;
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory accesses, sweep position and result
  always_comb begin
    clr_d       = clr_q;
    emit_init_d = emit_init_q;
    col_d       = col_q;
    row_d       = row_q;
    base_d      = base_q;
    addr_d      = addr_q;
    rand_d      = rand_q;
    res_d       = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = addr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = clr_q;
    ram_wdata_o = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = (clr_q >= AddrW'(BottomBase)) ? HeatMax : '0;
        clr_d       = clr_q + AddrW'(1);
        if (clr_last) begin
          clr_d       = '0;
          emit_init_d = 1'b0;
          col_d       = '0;
          row_d       = RowW'(1);
          base_d      = '0;
          addr_d      = AddrW'(GridWidth);
          res_d.valid = emit_init_q;
        end
      end
      ST_IDLE: begin
        if (start) begin
          rand_d = rand_bits_i;
          case (cmd_i)
            CMD_INIT: begin
              emit_init_d = 1'b1;
              clr_d       = '0;
            end
            CMD_PROPAGATE: begin
              ram_re_o    = 1'b1;
              ram_raddr_o = addr_q;
            end
            CMD_READ: begin
              if (in_range) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = read_addr;
              end else begin
                res_d.valid = 1'b1;
              end
            end
            default: begin
              res_d.valid = 1'b1;
              res_d.blank = 1'b1;
            end
          endcase
        end
      end
      ST_PROP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = base_q + AddrW'(nx);
        ram_wdata_o = w;
        res_d.valid = 1'b1;
        res_d.heat  = w;
        if (col_q == ColW'(GridWidth - 1)) begin
          col_d = '0;
          if (row_q == RowW'(GridHeight - 1)) begin
            row_d      = RowW'(1);
            base_d     = '0;
            addr_d     = AddrW'(GridWidth);
            res_d.done = 1'b1;
          end else begin
            row_d  = row_q + RowW'(1);
            base_d = base_q + AddrW'(GridWidth);
            addr_d = addr_q + AddrW'(1);
          end
        end else begin
          col_d  = col_q + ColW'(1);
          addr_d = addr_q + AddrW'(1);
        end
      end
      ST_READ: begin
        res_d.valid = 1'b1;
        res_d.heat  = ram_rdata_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      emit_init_q <= 1'b0;
      col_q       <= '0;
      row_q       <= RowW'(1);
      base_q      <= '0;
      addr_q      <= AddrW'(GridWidth);
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      emit_init_q <= emit_init_d;
      col_q       <= col_d;
      row_q       <= row_d;
      base_q      <= base_d;
      addr_q      <= addr_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rand_q <= rand_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> rtl/fire_effect_propagator_unit.sv
// Fire effect grid engine. The heat grid (GridWidth x GridHeight cells of
// 3 bits) lives in one single-port-write, single-port-read RAM with a
// registered read. After reset, and on every init command, a clearing
// pass writes one cell per cycle, and busy stays high throughout it; the
// init result follows that pass. For a propagate command, the cell is read
// in the accept cycle and its heat written to the row above in the next.
// An in-range read waits in the read state for the registered RAM data; an
// out-of-range read or an unused command finishes in the accept cycle.
// Each result appears on the cycle after the command finishes, with
// res_strobe_o high for that single cycle; there is no back-pressure, the
// receiver must take it then. Palette writes on the cfg port take effect
// on the next edge.
`default_nettype none

module fire_effect_propagator_unit import fep_pkg::*; #(
  parameter int GridWidth  = 160,
  parameter int GridHeight = 120
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [1:0]         rand_bits_i,
  input  wire logic [7:0]         col_i,
  input  wire logic [6:0]         row_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ColourW-1:0] cfg_data_i,
  output logic                    res_strobe_o,
  output logic      [HeatW-1:0]   heat_o,
  output logic      [7:0]         red_o,
  output logic      [7:0]         green_o,
  output logic      [7:0]         blue_o,
  output logic                    frame_done_o
);

  localparam int Cells = GridWidth * GridHeight;
  localparam int AddrW = $clog2(Cells);

  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [HeatW-1:0] ram_rdata;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [HeatW-1:0] ram_wdata;
  res_t             res;
  rgb_t             colour;

  fep_grid_ram #(
    .Depth (Cells),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata)
  );

  fep_seq #(
    .GridWidth  (GridWidth),
    .GridHeight (GridHeight),
    .AddrW      (AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .rand_bits_i (rand_bits_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .res_o       (res)
  );

  fep_palette u_palette (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_i      (res),
    .colour_o   (colour)
  );

  assign res_strobe_o = res.valid;
  assign heat_o       = res.heat;
  assign frame_done_o = res.done;
  assign red_o        = colour[23:16];
  assign green_o      = colour[15:8];
  assign blue_o       = colour[7:0];

endmodule

`default_nettype wire

>>> rtl/fep_checker.sv
`default_nettype none
`include "assert_macros.svh"

module fep_checker import fep_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [1:0]       cmd_i,
  input wire logic             res_strobe_o,
  input wire logic [HeatW-1:0] heat_o,
  input wire logic             frame_done_o
);

  logic acc_prop;
  logic acc_init;

  assign acc_prop = start && !busy && (cmd_i == CMD_PROPAGATE);
  assign acc_init = start && !busy && (cmd_i == CMD_INIT);

  // propagate: read then write, result on the following cycle
  `FEP_ASSERT(a_prop_busy, acc_prop |=> busy, "propagate transfer did not hold busy")
  `FEP_ASSERT(a_prop_result, acc_prop |-> ##2 res_strobe_o, "propagate result missing")
  `FEP_ASSERT(a_init_clear, acc_init |=> busy, "init did not start clearing pass")
  `FEP_ASSERT_NEVER(a_done_alone, frame_done_o && !res_strobe_o, "frame_done without result")
  `FEP_ASSERT_NEVER(a_heat_range, res_strobe_o && (heat_o > HeatMax), "heat above maximum")

endmodule

bind fire_effect_propagator_unit fep_checker u_fep_checker (.*);

`default_nettype wire
